// File: hw/rtl/srb_pkg.sv
`default_nettype none
package srb_pkg;

	localparam int unsigned RX_DEPTH_DEF    = 256;
	localparam int unsigned TX_DEPTH_DEF    = 256;
	localparam int unsigned COUNT_WIDTH_DEF = 16;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned TOTAL_W = 16;

	localparam logic [2:0] OP_RECEIVE = 3'd0;
	localparam logic [2:0] OP_WRITE   = 3'd1;
	localparam logic [2:0] OP_READ    = 3'd2;
	localparam logic [2:0] OP_PEEK    = 3'd3;
	localparam logic [2:0] OP_PULL    = 3'd4;
	localparam logic [2:0] OP_CLEAR   = 3'd5;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_BREAK   = 3'd1;
	localparam logic [2:0] ERR_OVERRUN = 3'd2;
	localparam logic [2:0] ERR_FRAMING = 3'd3;
	localparam logic [2:0] ERR_FULL    = 3'd4;

	localparam int unsigned CNT_BREAK   = 0;
	localparam int unsigned CNT_OVERRUN = 1;
	localparam int unsigned CNT_FRAMING = 2;
	localparam int unsigned CNT_RXFULL  = 3;
	localparam int unsigned CNT_TXFULL  = 4;
	localparam int unsigned NUM_CNT     = 5;

	typedef struct packed {
		logic push;
		logic rd;
		logic pop;
		logic clr;
	} ring_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ring_stat_t;

	typedef struct packed {
		logic brk;
		logic ovr;
		logic frm;
		logic rx_full;
		logic tx_full;
		logic clr;
	} err_ev_t;

endpackage
`default_nettype wire

// File: hw/rtl/srb_ring.sv
`default_nettype none
module srb_ring #(
	parameter int unsigned DEPTH = srb_pkg::RX_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire srb_pkg::ring_cmd_t          cmd,
	input  wire logic [srb_pkg::BYTE_W-1:0]  wr_data,
	output srb_pkg::ring_stat_t              stat,
	output logic [srb_pkg::BYTE_W-1:0]       rd_data,
	output logic [srb_pkg::LEVEL_W-1:0]      level
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned LW = (AW > srb_pkg::LEVEL_W) ? AW : srb_pkg::LEVEL_W;

	logic [srb_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [AW-1:0] put_q, get_q, put_nx, get_nx;
	logic [AW:0]   lvl_sum;
	logic [AW-1:0] lvl;
	logic [LW-1:0] lvl_wide;
	logic          push_ok, pop_ok, rd_ok;
	logic [srb_pkg::BYTE_W-1:0] rd_q;

	assign put_nx = (put_q == AW'(DEPTH - 1)) ? '0 : put_q + 1'b1;
	assign get_nx = (get_q == AW'(DEPTH - 1)) ? '0 : get_q + 1'b1;

	assign stat.full  = (put_nx == get_q);
	assign stat.empty = (put_q == get_q);

	assign push_ok = cmd.push && !stat.full;
	assign pop_ok  = cmd.pop && !stat.empty;
	assign rd_ok   = cmd.rd && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			put_q <= '0;
			get_q <= '0;
		end else if (cmd.clr) begin
			put_q <= '0;
			get_q <= '0;
		end else begin
			if (push_ok)
				put_q <= put_nx;
			if (pop_ok)
				get_q <= get_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok)
			mem[put_q] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_ok)
			rd_q <= mem[get_q];
	end

	assign rd_data = rd_q;

	// wrap the distance when put has gone around past get
	assign lvl_sum = (put_q >= get_q) ? ((AW+1)'(put_q) - (AW+1)'(get_q))
	                                  : ((AW+1)'(put_q) + (AW+1)'(DEPTH) - (AW+1)'(get_q));
	assign lvl      = lvl_sum[AW-1:0];
	assign lvl_wide = LW'(lvl);
	assign level    = lvl_wide[srb_pkg::LEVEL_W-1:0];

endmodule
`default_nettype wire

// File: hw/rtl/srb_err.sv
`default_nettype none
module srb_err #(
	parameter int unsigned COUNT_WIDTH = srb_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire srb_pkg::err_ev_t         ev,
	output logic [2:0]                    first_error,
	output logic [srb_pkg::TOTAL_W-1:0]   totals [srb_pkg::NUM_CNT]
);

	localparam int unsigned XW = (COUNT_WIDTH > srb_pkg::TOTAL_W) ? COUNT_WIDTH
	                                                              : srb_pkg::TOTAL_W;

	logic [COUNT_WIDTH-1:0] cnt_q [srb_pkg::NUM_CNT];
	logic [srb_pkg::NUM_CNT-1:0] bump;
	logic [2:0] err_q, err_code;
	logic [XW-1:0] cnt_wide [srb_pkg::NUM_CNT];

	assign bump[srb_pkg::CNT_BREAK]   = ev.brk;
	assign bump[srb_pkg::CNT_OVERRUN] = ev.ovr;
	assign bump[srb_pkg::CNT_FRAMING] = ev.frm;
	assign bump[srb_pkg::CNT_RXFULL]  = ev.rx_full;
	assign bump[srb_pkg::CNT_TXFULL]  = ev.tx_full;

	// line errors take precedence over the full drop in the same transfer
	always_comb begin
		if (ev.brk)
			err_code = srb_pkg::ERR_BREAK;
		else if (ev.ovr)
			err_code = srb_pkg::ERR_OVERRUN;
		else if (ev.frm)
			err_code = srb_pkg::ERR_FRAMING;
		else if (ev.rx_full)
			err_code = srb_pkg::ERR_FULL;
		else
			err_code = srb_pkg::ERR_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			err_q <= srb_pkg::ERR_NONE;
		else if (err_q == srb_pkg::ERR_NONE)
			err_q <= err_code;
	end

	for (genvar i = 0; i < srb_pkg::NUM_CNT; i++) begin : g_cnt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cnt_q[i] <= '0;
			else if (ev.clr)
				cnt_q[i] <= '0;
			else if (bump[i] && (cnt_q[i] != '1))
				cnt_q[i] <= cnt_q[i] + 1'b1;
		end
		assign cnt_wide[i] = XW'(cnt_q[i]);
		assign totals[i]   = cnt_wide[i][srb_pkg::TOTAL_W-1:0];
	end

	assign first_error = err_q;

endmodule
`default_nettype wire

// File: hw/rtl/serial_ring_buffers_with_error_status.sv
`default_nettype none
// Channel | Handshake                    | Payload
// in      | in_valid / in_ready           | opcode, byte_in, break_flag, overrun_flag, framing_flag
// out     | out_valid / out_ready         | data_byte, data_valid, accepted, rx_level, tx_level,
//         |                              | first_error, *_total
// Pointers, counters and the error latch update at the input transfer, and the ring
// memory read is registered on that same edge; the result then moves from the read
// stage into the output register once that register is free or being taken, and is
// offered from there. A new one is taken every cycle while the output side keeps up.
// While a result waits in the read stage and the output register is blocked, input
// holds off. Reset empties both rings and zeroes counters; memory content is left.
module serial_ring_buffers_with_error_status #(
	parameter int unsigned RX_DEPTH    = srb_pkg::RX_DEPTH_DEF,
	parameter int unsigned TX_DEPTH    = srb_pkg::TX_DEPTH_DEF,
	parameter int unsigned COUNT_WIDTH = srb_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [2:0]                   opcode,
	input  wire logic [srb_pkg::BYTE_W-1:0]   byte_in,
	input  wire logic                         break_flag,
	input  wire logic                         overrun_flag,
	input  wire logic                         framing_flag,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [srb_pkg::BYTE_W-1:0]        data_byte,
	output logic                              data_valid,
	output logic                              accepted,
	output logic [srb_pkg::LEVEL_W-1:0]       rx_level,
	output logic [srb_pkg::LEVEL_W-1:0]       tx_level,
	output logic [2:0]                        first_error,
	output logic [srb_pkg::TOTAL_W-1:0]       break_total,
	output logic [srb_pkg::TOTAL_W-1:0]       overrun_total,
	output logic [srb_pkg::TOTAL_W-1:0]       framing_total,
	output logic [srb_pkg::TOTAL_W-1:0]       rx_full_total,
	output logic [srb_pkg::TOTAL_W-1:0]       tx_full_total
);

	logic xfer, adv;
	logic op_rx, op_wr, op_rd, op_pk, op_pull, op_clr;
	srb_pkg::ring_cmd_t  rx_cmd, tx_cmd;
	srb_pkg::ring_stat_t rx_stat, tx_stat;
	srb_pkg::err_ev_t    ev;
	logic [srb_pkg::BYTE_W-1:0]  rx_rd, tx_rd;
	logic [srb_pkg::LEVEL_W-1:0] rx_lvl, tx_lvl;
	logic [2:0]                  err_cur;
	logic [srb_pkg::TOTAL_W-1:0] totals [srb_pkg::NUM_CNT];

	logic pend_s1, dvalid_s1, from_tx_s1, acc_s1;
	logic out_valid_q, data_valid_q, accepted_q;
	logic [srb_pkg::BYTE_W-1:0]  data_byte_q;
	logic [srb_pkg::LEVEL_W-1:0] rx_level_q, tx_level_q;
	logic [2:0]                  first_error_q;
	logic [srb_pkg::TOTAL_W-1:0] totals_q [srb_pkg::NUM_CNT];

	assign adv      = pend_s1 && (!out_valid_q || out_ready);
	assign in_ready = !pend_s1 || adv;
	assign xfer     = in_valid && in_ready;

	assign op_rx   = xfer && (opcode == srb_pkg::OP_RECEIVE);
	assign op_wr   = xfer && (opcode == srb_pkg::OP_WRITE);
	assign op_rd   = xfer && (opcode == srb_pkg::OP_READ);
	assign op_pk   = xfer && (opcode == srb_pkg::OP_PEEK);
	assign op_pull = xfer && (opcode == srb_pkg::OP_PULL);
	assign op_clr  = xfer && (opcode == srb_pkg::OP_CLEAR);

	assign rx_cmd.push = op_rx;
	assign rx_cmd.rd   = op_rd || op_pk;
	assign rx_cmd.pop  = op_rd;
	assign rx_cmd.clr  = op_clr;

	assign tx_cmd.push = op_wr;
	assign tx_cmd.rd   = op_pull;
	assign tx_cmd.pop  = op_pull;
	assign tx_cmd.clr  = 1'b0;

	assign ev.brk     = op_rx && break_flag;
	assign ev.ovr     = op_rx && !break_flag && overrun_flag;
	assign ev.frm     = op_rx && !break_flag && !overrun_flag && framing_flag;
	assign ev.rx_full = op_rx && rx_stat.full;
	assign ev.tx_full = op_wr && tx_stat.full;
	assign ev.clr     = op_clr;

	srb_ring #(.DEPTH(RX_DEPTH)) u_rx (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (rx_cmd),
		.wr_data (byte_in),
		.stat    (rx_stat),
		.rd_data (rx_rd),
		.level   (rx_lvl)
	);

	srb_ring #(.DEPTH(TX_DEPTH)) u_tx (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (tx_cmd),
		.wr_data (byte_in),
		.stat    (tx_stat),
		.rd_data (tx_rd),
		.level   (tx_lvl)
	);

	srb_err #(.COUNT_WIDTH(COUNT_WIDTH)) u_err (
		.clk         (clk),
		.arst_n      (arst_n),
		.ev          (ev),
		.first_error (err_cur),
		.totals      (totals)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_s1 <= 1'b0;
		else if (xfer)
			pend_s1 <= 1'b1;
		else if (adv)
			pend_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			dvalid_s1  <= ((op_rd || op_pk) && !rx_stat.empty) || (op_pull && !tx_stat.empty);
			from_tx_s1 <= op_pull;
			acc_s1     <= (op_rx && !rx_stat.full) || (op_wr && !tx_stat.full);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// state is frozen while the read stage waits, so the live status belongs to it
	always_ff @(posedge clk) begin
		if (adv) begin
			data_valid_q  <= dvalid_s1;
			data_byte_q   <= !dvalid_s1 ? '0 : (from_tx_s1 ? tx_rd : rx_rd);
			accepted_q    <= acc_s1;
			rx_level_q    <= rx_lvl;
			tx_level_q    <= tx_lvl;
			first_error_q <= err_cur;
			totals_q      <= totals;
		end
	end

	assign out_valid     = out_valid_q;
	assign data_byte     = data_byte_q;
	assign data_valid    = data_valid_q;
	assign accepted      = accepted_q;
	assign rx_level      = rx_level_q;
	assign tx_level      = tx_level_q;
	assign first_error   = first_error_q;
	assign break_total   = totals_q[srb_pkg::CNT_BREAK];
	assign overrun_total = totals_q[srb_pkg::CNT_OVERRUN];
	assign framing_total = totals_q[srb_pkg::CNT_FRAMING];
	assign rx_full_total = totals_q[srb_pkg::CNT_RXFULL];
	assign tx_full_total = totals_q[srb_pkg::CNT_TXFULL];

endmodule
`default_nettype wire
